>>> rtl/yrc_pkg.sv
// Shared constants, types and the clamp helper for the YUV 4:2:0 to RGBA converter.
package yrc_pkg;

   localparam int BYTE_W     = 8;
   localparam int CHROMA_W   = 2 * BYTE_W;
   localparam int PIX_W      = 32;
   localparam int WP_W       = 12;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 2;

   localparam logic [WP_W-1:0] WP_RESET = 12'd320;

   // Signed width of the fixed-point color sums (range about -265k..+548k).
   localparam int SUM_W = 21;

   localparam logic signed [SUM_W-1:0] COEF_Y    = 21'sd1192;
   localparam logic signed [SUM_W-1:0] COEF_RV   = 21'sd1634;
   localparam logic signed [SUM_W-1:0] COEF_GV   = 21'sd833;
   localparam logic signed [SUM_W-1:0] COEF_GU   = 21'sd400;
   localparam logic signed [SUM_W-1:0] COEF_BU   = 21'sd2066;
   localparam logic signed [SUM_W-1:0] CLAMP_MAX = 21'sd262143;
   localparam int                      CLAMP_SHIFT = 10;

   localparam logic [BYTE_W-1:0]  LUMA_OFFSET   = 8'd16;
   localparam logic signed [8:0]  CHROMA_OFFSET = 9'sd128;
   localparam logic [BYTE_W-1:0]  ALPHA         = 8'hff;

   // Output queue; depth must be a power of two so the pointers wrap.
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic [PIX_W-1:0] pixel_first;
      logic [PIX_W-1:0] pixel_second;
      logic             row_end;
   } result_type;

   function automatic logic [BYTE_W-1:0] clamp_shift(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] sh;
      sh = s >>> CLAMP_SHIFT;
      if (s < 0) return '0;
      if (s > CLAMP_MAX) return {BYTE_W{1'b1}};
      return sh[BYTE_W-1:0];
   endfunction

endpackage

>>> rtl/yrc_if.sv
// Request and response channel interfaces of the converter.
interface yrc_req_if import yrc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] luma_first;
   logic [BYTE_W-1:0] luma_second;
   logic [BYTE_W-1:0] chroma_u;
   logic [BYTE_W-1:0] chroma_v;
   logic              frame_start;

   modport source (output valid, luma_first, luma_second, chroma_u, chroma_v, frame_start,
                   input ready);
   modport sink   (input valid, luma_first, luma_second, chroma_u, chroma_v, frame_start,
                   output ready);
endinterface

interface yrc_rsp_if import yrc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_first;
   logic [PIX_W-1:0] pixel_second;
   logic             row_end;

   modport source (output valid, pixel_first, pixel_second, row_end, input ready);
   modport sink   (input valid, pixel_first, pixel_second, row_end, output ready);
endinterface

>>> rtl/yrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module yrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/yrc_lane.sv
// One color conversion lane: BT.601 fixed point, two register stages.
module yrc_lane import yrc_pkg::*; (
   input  logic              clock,
   input  logic [BYTE_W-1:0] luma,
   input  logic [BYTE_W-1:0] chroma_u,
   input  logic [BYTE_W-1:0] chroma_v,
   output logic [PIX_W-1:0]  pixel
);

   logic [BYTE_W-1:0]       y_off;
   logic signed [8:0]       u_off;
   logic signed [8:0]       v_off;
   logic signed [SUM_W-1:0] y_ext;
   logic signed [SUM_W-1:0] u_ext;
   logic signed [SUM_W-1:0] v_ext;

   logic signed [SUM_W-1:0] yt_in, yt_ff;
   logic signed [SUM_W-1:0] rv_in, rv_ff;
   logic signed [SUM_W-1:0] gv_in, gv_ff;
   logic signed [SUM_W-1:0] gu_in, gu_ff;
   logic signed [SUM_W-1:0] bu_in, bu_ff;

   logic signed [SUM_W-1:0] r_sum;
   logic signed [SUM_W-1:0] g_sum;
   logic signed [SUM_W-1:0] b_sum;
   logic [PIX_W-1:0]        pixel_in, pixel_ff;

   // Stage A: offsets and constant products
   always_comb begin
      y_off = (luma < LUMA_OFFSET) ? '0 : luma - LUMA_OFFSET;
      u_off = $signed({1'b0, chroma_u}) - CHROMA_OFFSET;
      v_off = $signed({1'b0, chroma_v}) - CHROMA_OFFSET;
      y_ext = SUM_W'(y_off);
      u_ext = SUM_W'(u_off);
      v_ext = SUM_W'(v_off);
      yt_in = y_ext * COEF_Y;
      rv_in = v_ext * COEF_RV;
      gv_in = v_ext * COEF_GV;
      gu_in = u_ext * COEF_GU;
      bu_in = u_ext * COEF_BU;
   end

   // Stage B: sums, clamp, pack (red in the low byte)
   always_comb begin
      r_sum    = yt_ff + rv_ff;
      g_sum    = yt_ff - gv_ff - gu_ff;
      b_sum    = yt_ff + bu_ff;
      pixel_in = {ALPHA, clamp_shift(b_sum), clamp_shift(g_sum), clamp_shift(r_sum)};
   end

   always_ff @(posedge clock) begin
      yt_ff    <= yt_in;
      rv_ff    <= rv_in;
      gv_ff    <= gv_in;
      gu_ff    <= gu_in;
      bu_ff    <= bu_in;
      pixel_ff <= pixel_in;
   end

   assign pixel = pixel_ff;

endmodule

>>> rtl/yrc_merge.sv
// Merges both lane pixels and the row flag into the output queue feeding the response channel.
module yrc_merge import yrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  result_type       entry,
   yrc_rsp_if.source        rsp_bus
);

   result_type             queue_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;
   result_type             head;

   assign head                 = queue_ff[rd_ptr_ff];
   assign rsp_bus.valid        = (count_ff != '0);
   assign rsp_bus.pixel_first  = head.pixel_first;
   assign rsp_bus.pixel_second = head.pixel_second;
   assign rsp_bus.row_end      = head.row_end;
   assign pop                  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + OUT_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + OUT_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != OUT_CNT_W'(OUT_DEPTH) || pop))
      else $error("output queue overflow");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + OUT_CNT_W'(1))
      else $error("output queue count did not advance on push");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> rsp_bus.valid)
      else $error("response withdrawn before acceptance");

endmodule

>>> rtl/yuv420_to_rgba_converter_unit.sv
// Top level of the YUV 4:2:0 to packed RGBA converter.
// Usage:
//   req_bus carries one request per pixel pair in raster order: two luma bytes, one U/V
//   pair and frame_start, which restarts column and row parity at this pair. U/V are
//   taken and stored on even rows; odd rows reuse the stored chroma of the same column.
//   rsp_bus returns one response per request: two packed pixels (alpha, blue, green,
//   red with red in the low byte) and row_end on the last pair of each row.
//   The APB port holds width_pairs at address 0 (pairs per row, 0 acts as 1, values
//   above MAX_PAIRS act as MAX_PAIRS); write it only while no request is in flight.
// Timing:
//   A request passes the chroma line memory read, the product stage of the two lanes,
//   then the sum/clamp stage, into an 8-entry output queue. Throughput is one request
//   per cycle while req_bus.ready is high.
//   req_bus.ready drops once 8 requests are accepted and not yet delivered, so a
//   stalled receiver backs up into the queue and nothing is lost.
// Reset:
//   width_pairs returns to 320, column 0, even row. The chroma line memory is not
//   cleared; an odd row must follow an even row that wrote its columns.
module yuv420_to_rgba_converter_unit import yrc_pkg::*; #(
   parameter int MAX_PAIRS = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   yrc_req_if.sink               req_bus,
   yrc_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int COL_W   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int PAIRS_W = $clog2(MAX_PAIRS + 1);
   localparam int CMP_W   = (PAIRS_W > WP_W) ? PAIRS_W : WP_W;

   function automatic logic [COL_W-1:0] last_col_of(input logic [WP_W-1:0] wp);
      logic [CMP_W-1:0] pairs;
      pairs = CMP_W'(wp);
      if (pairs == '0) pairs = CMP_W'(1);
      if (pairs > CMP_W'(MAX_PAIRS)) pairs = CMP_W'(MAX_PAIRS);
      return COL_W'(pairs - CMP_W'(1));
   endfunction

   // configuration
   logic              cfg_write;
   logic [WP_W-1:0]   width_pairs_ff;
   logic [COL_W-1:0]  last_col_ff;

   // request side
   logic              req_accept;
   logic              rsp_pop;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              odd_ff, odd_in;
   logic [COL_W-1:0]  base_col;
   logic              base_odd;
   logic [COL_W-1:0]  acc_col;
   logic              acc_last;
   logic [OUT_CNT_W-1:0] out_cnt_ff, out_cnt_in;

   // pipeline
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic              s1_last_ff, s2_last_ff, s3_last_ff;
   logic              s1_odd_ff;
   logic [BYTE_W-1:0] s1_luma_first_ff, s1_luma_second_ff;
   logic [BYTE_W-1:0] s1_u_ff, s1_v_ff;
   logic [CHROMA_W-1:0] ram_rd_data;
   logic [CHROMA_W-1:0] s1_chroma;
   logic [PIX_W-1:0]  lane_pixel_first, lane_pixel_second;
   result_type        merge_entry;

   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = APB_DATA_W'(width_pairs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_pairs_ff <= WP_RESET;
         last_col_ff    <= last_col_of(WP_RESET);
      end else if (cfg_write) begin
         width_pairs_ff <= pwdata[WP_W-1:0];
         last_col_ff    <= last_col_of(pwdata[WP_W-1:0]);
      end
   end

   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_pop       = rsp_bus.valid && rsp_bus.ready;
   assign req_bus.ready = (out_cnt_ff != OUT_CNT_W'(OUT_DEPTH));

   always_comb begin
      base_col   = req_bus.frame_start ? '0 : col_ff;
      base_odd   = req_bus.frame_start ? 1'b0 : odd_ff;
      acc_col    = (base_col > last_col_ff) ? last_col_ff : base_col;
      acc_last   = (acc_col == last_col_ff);
      col_in     = col_ff;
      odd_in     = odd_ff;
      if (req_accept) begin
         col_in = acc_last ? '0 : acc_col + COL_W'(1);
         odd_in = acc_last ? !base_odd : base_odd;
      end
      out_cnt_in = out_cnt_ff + OUT_CNT_W'(req_accept) - OUT_CNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         odd_ff      <= 1'b0;
         out_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         odd_ff      <= odd_in;
         out_cnt_ff  <= out_cnt_in;
         s1_valid_ff <= req_accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff        <= acc_last;
      s1_odd_ff         <= base_odd;
      s1_luma_first_ff  <= req_bus.luma_first;
      s1_luma_second_ff <= req_bus.luma_second;
      s1_u_ff           <= req_bus.chroma_u;
      s1_v_ff           <= req_bus.chroma_v;
      s2_last_ff        <= s1_last_ff;
      s3_last_ff        <= s2_last_ff;
   end

   // even rows write U/V (U in the low byte), odd rows read them back
   yrc_ram #(
      .WIDTH (CHROMA_W),
      .DEPTH (MAX_PAIRS)
   ) u_chroma_line (
      .clock   (clock),
      .wr_en   (req_accept && !base_odd),
      .wr_addr (acc_col),
      .wr_data ({req_bus.chroma_v, req_bus.chroma_u}),
      .rd_en   (req_accept && base_odd),
      .rd_addr (acc_col),
      .rd_data (ram_rd_data)
   );

   assign s1_chroma = s1_odd_ff ? ram_rd_data : {s1_v_ff, s1_u_ff};

   yrc_lane u_lane_first (
      .clock    (clock),
      .luma     (s1_luma_first_ff),
      .chroma_u (s1_chroma[BYTE_W-1:0]),
      .chroma_v (s1_chroma[CHROMA_W-1:BYTE_W]),
      .pixel    (lane_pixel_first)
   );

   yrc_lane u_lane_second (
      .clock    (clock),
      .luma     (s1_luma_second_ff),
      .chroma_u (s1_chroma[BYTE_W-1:0]),
      .chroma_v (s1_chroma[CHROMA_W-1:BYTE_W]),
      .pixel    (lane_pixel_second)
   );

   always_comb begin
      merge_entry.pixel_first  = lane_pixel_first;
      merge_entry.pixel_second = lane_pixel_second;
      merge_entry.row_end      = s3_last_ff;
   end

   yrc_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .push    (s3_valid_ff),
      .entry   (merge_entry),
      .rsp_bus (rsp_bus)
   );

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= OUT_CNT_W'(OUT_DEPTH))
      else $error("outstanding request count above queue depth");

   a_credit_up: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !rsp_pop) |=> out_cnt_ff == $past(out_cnt_ff) + OUT_CNT_W'(1))
      else $error("outstanding count missed an accepted request");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_accept && acc_last) |=> (col_ff == '0 && odd_ff != $past(base_odd)))
      else $error("row end did not restart column and flip parity");

endmodule

>>> verif/yrc_tb_pkg.sv
// Request type and expected-pixel tracker for the YUV 4:2:0 to RGBA converter bench.
package yrc_tb_pkg;
   import yrc_pkg::*;

   localparam int unsigned LINE_PAIRS      = 2048;
   localparam int unsigned REG_WIDTH_PAIRS = 0;
   localparam int unsigned MAX_REPORTS     = 10;

   // BT.601 gains, scaled by 1024
   localparam int Y_GAIN      = 1192;
   localparam int R_V_GAIN    = 1634;
   localparam int G_V_GAIN    = 833;
   localparam int G_U_GAIN    = 400;
   localparam int B_U_GAIN    = 2066;
   localparam int SUM_CEIL    = 262143;
   localparam int FRAC_BITS   = 10;
   localparam int LUMA_BLACK  = 16;
   localparam int CHROMA_ZERO = 128;
   localparam logic [7:0] OPAQUE = 8'hff;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] luma_second;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
      logic       frame_start;
   } pair_req_type;

   class rgba_pair_tracker;
      logic [WP_W-1:0] width_pairs_reg;
      int unsigned     column;
      bit              odd_row;
      logic [15:0]     chroma_mem [LINE_PAIRS];
      bit              chroma_seen [LINE_PAIRS];
      result_type      expected_q [$];
      int unsigned     requests, responses, mismatches;
      int unsigned     row_ends, odd_pairs, frame_starts;

      function new();
         width_pairs_reg = WP_RESET;
         column = 0;
         odd_row = 0;
         foreach (chroma_seen[i]) chroma_seen[i] = 0;
      endfunction

      function int unsigned row_pairs();
         int unsigned p;
         p = width_pairs_reg;
         if (p < 1) p = 1;
         if (p > LINE_PAIRS) p = LINE_PAIRS;
         return p;
      endfunction

      // column a request lands on, clamped when the row was shortened mid-row
      function int unsigned next_column(bit frame_start);
         if (frame_start) return 0;
         return (column >= row_pairs()) ? row_pairs() - 1 : column;
      endfunction

      // odd row about to read a chroma entry nobody wrote
      function bit needs_restart();
         return odd_row && !chroma_seen[next_column(1'b0)];
      endfunction

      static function logic [7:0] scale_channel(int s);
         if (s < 0) s = 0;
         if (s > SUM_CEIL) s = SUM_CEIL;
         return 8'(s >> FRAC_BITS);
      endfunction

      static function logic [31:0] convert_to_rgba(logic [7:0] y, logic [7:0] u, logic [7:0] v);
         int yy, uu, vv;
         yy = int'(y) - LUMA_BLACK;
         if (yy < 0) yy = 0;
         uu = int'(u) - CHROMA_ZERO;
         vv = int'(v) - CHROMA_ZERO;
         return {OPAQUE,
                 scale_channel(Y_GAIN * yy + B_U_GAIN * uu),
                 scale_channel(Y_GAIN * yy - G_V_GAIN * vv - G_U_GAIN * uu),
                 scale_channel(Y_GAIN * yy + R_V_GAIN * vv)};
      endfunction

      function void note_request(pair_req_type r);
         int unsigned col;
         logic [7:0]  u, v;
         result_type  want;
         if (r.frame_start) begin
            column = 0;
            odd_row = 0;
            frame_starts++;
         end
         col = next_column(1'b0);
         if (!odd_row) begin
            chroma_mem[col] = {r.chroma_v, r.chroma_u};
            chroma_seen[col] = 1;
            u = r.chroma_u;
            v = r.chroma_v;
         end else begin
            u = chroma_mem[col][7:0];
            v = chroma_mem[col][15:8];
            odd_pairs++;
         end
         want.pixel_first  = convert_to_rgba(r.luma_first, u, v);
         want.pixel_second = convert_to_rgba(r.luma_second, u, v);
         want.row_end      = (col == row_pairs() - 1);
         expected_q.push_back(want);
         if (want.row_end) begin
            column = 0;
            odd_row = !odd_row;
            row_ends++;
         end else begin
            column = col + 1;
         end
         requests++;
      endfunction

      function void check_response(result_type got);
         result_type want;
         responses++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: response with nothing pending: %h %h row_end=%b",
                        got.pixel_first, got.pixel_second, got.row_end);
            return;
         end
         want = expected_q.pop_front();
         if (got.pixel_first !== want.pixel_first || got.pixel_second !== want.pixel_second ||
             got.row_end !== want.row_end) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: response %0d expected %h %h row_end=%b, got %h %h row_end=%b",
                        responses, want.pixel_first, want.pixel_second, want.row_end,
                        got.pixel_first, got.pixel_second, got.row_end);
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

>>> verif/yuv420_to_rgba_converter_unit_tb.sv
// Self-checking bench for the YUV 4:2:0 to RGBA converter top level.
module yuv420_to_rgba_converter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import yrc_pkg::*;
   import yrc_tb_pkg::*;

   localparam int unsigned LATENCY    = 3;
   localparam int unsigned IDLE_LIMIT = 4000;
   localparam int unsigned LONG_HOLD  = 80;
   localparam int unsigned MAX_WAIT   = 13;
   localparam int unsigned NUM_PHASES = 10;
   localparam int unsigned PHASE_LEN  = 160;
   localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR = APB_ADDR_W'(REG_WIDTH_PAIRS * 4);

   localparam logic [WP_W-1:0] WIDTH_PLAN [7] = '{12'd1, 12'd2, 12'd3, 12'd2049, 12'd5,
                                                 12'd2048, 12'd1};

   // run at one pair per row, so requests alternate even and odd rows except where frame_start restarts at an even row
   localparam pair_req_type DIRECTED [20] = '{
      '{8'd0,   8'd255, 8'd0,   8'd0,   1'b1},
      '{8'd255, 8'd0,   8'd255, 8'd255, 1'b0},
      '{8'd16,  8'd15,  8'd255, 8'd255, 1'b0},
      '{8'd17,  8'd235, 8'd0,   8'd0,   1'b0},
      '{8'd255, 8'd255, 8'd0,   8'd255, 1'b0},
      '{8'd128, 8'd128, 8'd255, 8'd0,   1'b0},
      '{8'd255, 8'd255, 8'd255, 8'd0,   1'b0},
      '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0},
      '{8'd128, 8'd64,  8'd128, 8'd128, 1'b0},
      '{8'd200, 8'd100, 8'd77,  8'd33,  1'b1},
      '{8'd50,  8'd60,  8'd1,   8'd254, 1'b1},
      '{8'd90,  8'd91,  8'd170, 8'd85,  1'b0},
      '{8'd1,   8'd254, 8'd85,  8'd170, 1'b0},
      '{8'd254, 8'd1,   8'd127, 8'd129, 1'b0},
      '{8'd235, 8'd16,  8'd240, 8'd16,  1'b0},
      '{8'd100, 8'd150, 8'd16,  8'd240, 1'b0},
      '{8'd255, 8'd255, 8'd128, 8'd255, 1'b0},
      '{8'd255, 8'd255, 8'd255, 8'd128, 1'b0},
      '{8'd0,   8'd255, 8'd0,   8'd128, 1'b0},
      '{8'd255, 8'd0,   8'd128, 8'd0,   1'b0}
   };

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [APB_ADDR_W-1:0] paddr;
   logic [APB_DATA_W-1:0] pwdata;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   yrc_req_if req_if ();
   yrc_rsp_if rsp_if ();

   yuv420_to_rgba_converter_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   rgba_pair_tracker tracker;
   int unsigned      stall_hold;
   int unsigned      rsp_mode;
   int unsigned      idle_cycles;
   int unsigned      width_writes;
   int unsigned      csr_errors;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mode 0: no idling, 1: uniform waits, 2: mostly back to back
   function automatic int unsigned draw_wait(int unsigned mode);
      if (mode == 0) return 0;
      if (mode == 1) return $urandom_range(0, MAX_WAIT);
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
   endfunction

   // bytes leaning toward the clamp regions
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'($urandom_range(0, 20));
         1: return 8'($urandom_range(230, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pair_req_type random_pair(int unsigned fs_odds);
      pair_req_type r;
      r.luma_first  = pick_byte();
      r.luma_second = pick_byte();
      r.chroma_u    = pick_byte();
      r.chroma_v    = pick_byte();
      r.frame_start = (fs_odds != 0) && ($urandom_range(1, fs_odds) == 1);
      return r;
   endfunction

   // called and returns at a falling edge
   task automatic send_pair(input pair_req_type r, input int unsigned gap);
      r.frame_start = r.frame_start | tracker.needs_restart();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.luma_first  <= r.luma_first;
      req_if.luma_second <= r.luma_second;
      req_if.chroma_u    <= r.chroma_u;
      req_if.chroma_v    <= r.chroma_v;
      req_if.frame_start <= r.frame_start;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   // write width_pairs, then read it back
   task automatic program_width(input logic [WP_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= WIDTH_ADDR;
      pwdata  <= APB_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      tracker.width_pairs_reg = value;
      width_writes++;
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== APB_DATA_W'(value)) begin
         csr_errors++;
         $display("ERROR: width_pairs read back %h, expected %h", prdata, value);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic run_phase(input bit write_width, input logic [WP_W-1:0] width,
                            input int unsigned n, input int unsigned fs_odds,
                            input bit long_stall, input bit pause_mid);
      int unsigned mode;
      int unsigned gap;
      mode = $urandom_range(0, 2);
      if (write_width) program_width(width);
      // sender keeps offering while the receiver holds off, so the queue fills
      if (long_stall) stall_hold = LONG_HOLD;
      for (int unsigned i = 0; i < n; i++) begin
         if (pause_mid && i == n / 2) drain();
         gap = (long_stall && i < 2 * LONG_HOLD) ? 0 : draw_wait(mode);
         send_pair(random_pair(fs_odds), gap);
      end
      drain();
   endtask

   // response side
   initial begin
      int unsigned w;
      result_type  got;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (stall_hold > 0) begin
            w = stall_hold;
            stall_hold = 0;
         end else begin
            w = draw_wait(rsp_mode);
         end
         if (w > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
         got.pixel_first  = rsp_if.pixel_first;
         got.pixel_second = rsp_if.pixel_second;
         got.row_end      = rsp_if.row_end;
         tracker.check_response(got);
         if ($urandom_range(0, 49) == 0) rsp_mode = $urandom_range(0, 2);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("ERROR: no request or response moved for %0d cycles", IDLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [WP_W-1:0] width;
      int unsigned     errors;
      tracker            = new();
      stall_hold         = 0;
      rsp_mode           = 1;
      idle_cycles        = 0;
      width_writes       = 0;
      csr_errors         = 0;
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_if.valid       = 1'b0;
      req_if.luma_first  = '0;
      req_if.luma_second = '0;
      req_if.chroma_u    = '0;
      req_if.chroma_v    = '0;
      req_if.frame_start = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset width of 320 pairs, left unwritten
      run_phase(1'b0, WP_RESET, 300, 60, 1'b0, 1'b0);

      // width 0 behaves as one pair per row
      program_width('0);
      foreach (DIRECTED[i]) send_pair(DIRECTED[i], draw_wait(1));
      drain();

      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         width = (p < 7) ? WIDTH_PLAN[p] : WP_W'($urandom_range(4, 40));
         run_phase(1'b1, width, PHASE_LEN, 50, p == 0, p == 2);
      end

      // top register value clamps to the largest row size
      run_phase(1'b1, '1, 100, 0, 1'b0, 1'b0);

      req_if.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4 * LATENCY) @(negedge clock);

      errors = tracker.mismatches + csr_errors + tracker.pending();
      $display("Converted %0d pixel pairs over %0d width settings: %0d row ends, %0d odd-row pairs",
               tracker.requests, width_writes + 1, tracker.row_ends, tracker.odd_pairs);
      $display("Frame restarts %0d, response mismatches %0d, register errors %0d",
               tracker.frame_starts, tracker.mismatches, csr_errors);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
